/* src/sfr_pkg.sv */
package sfr_pkg;

  localparam int unsigned FRAME_STORE_DEPTH = 38;

  // Frame byte values and positions
  localparam logic [7:0] START_BYTE     = 8'd2;
  localparam logic [7:0] END_BYTE       = 8'd3;
  localparam logic [7:0] HUNT_POS       = 8'd0;
  localparam logic [7:0] LEN_POS        = 8'd1;
  localparam logic [7:0] ADDR_POS       = 8'd2;
  localparam logic [7:0] SHORT_LAST_POS = 8'd11;
  localparam logic [7:0] LONG_LAST_POS  = 8'd37;
  localparam logic [7:0] SHORT_LEN      = 8'd12;
  localparam logic [7:0] LONG_LEN       = 8'd38;

  // Payload run
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned PAYLOAD_FIRST = 4;
  localparam logic [IDX_W-1:0] PAYLOAD_LAST_IDX = 6'd32;

  // Result kinds
  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  localparam int unsigned CMD_Q_DEPTH = 2;

  typedef enum logic {
    CMD_SHORT = 1'b0,
    CMD_LONG  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic long_pending;
    logic item_taken;
  } front_status_t;

endpackage

/* src/sfr_front.sv */
module sfr_front #(
  parameter int unsigned Depth = sfr_pkg::FRAME_STORE_DEPTH,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_wdata_i,
  input  logic                   push,
  input  logic [7:0]             rx_byte_i,
  output logic                   full,
  output logic                   cmd_push_o,
  output sfr_pkg::cmd_e          cmd_o,
  input  sfr_pkg::q_status_t     q_stat_i,
  input  logic                   run_done_i,
  input  logic                   rd_en_i,
  input  logic [AW-1:0]          rd_addr_i,
  output logic [7:0]             rd_data_o,
  output sfr_pkg::front_status_t stat_o
);

  logic [7:0] cnt_q, exp_q, exp_d, addr_byte_q, station_q;
  logic [8:0] cnt_n;
  logic       long_pend_q;
  logic       accept;
  logic       emit;
  sfr_pkg::cmd_e cmd;
  logic [7:0] mem [Depth];
  logic [7:0] rd_data_q;

  // Hold input off while a payload run still needs the frame store or the command queue is full
  assign full   = long_pend_q || q_stat_i.full;
  assign accept = push && !full;

  always_comb begin
    cnt_n = {1'b0, cnt_q};
    exp_d = exp_q;
    emit  = 1'b0;
    cmd   = sfr_pkg::CMD_SHORT;
    case (cnt_q)
      sfr_pkg::HUNT_POS: begin
        if (rx_byte_i == sfr_pkg::START_BYTE) cnt_n = {1'b0, sfr_pkg::LEN_POS};
      end
      sfr_pkg::LEN_POS: begin
        cnt_n = {1'b0, sfr_pkg::ADDR_POS};
        exp_d = rx_byte_i;
      end
      sfr_pkg::SHORT_LAST_POS: begin
        cnt_n = {1'b0, sfr_pkg::SHORT_LEN};
        if (exp_q == sfr_pkg::SHORT_LEN && rx_byte_i == sfr_pkg::END_BYTE) begin
          cnt_n = 9'd0;
          if (addr_byte_q == station_q) begin
            emit = 1'b1;
            cmd  = sfr_pkg::CMD_SHORT;
          end
        end
      end
      sfr_pkg::LONG_LAST_POS: begin
        cnt_n = {1'b0, sfr_pkg::LONG_LEN};
        if (exp_q == sfr_pkg::LONG_LEN && rx_byte_i == sfr_pkg::END_BYTE) begin
          cnt_n = 9'd0;
          emit  = 1'b1;
          cmd   = sfr_pkg::CMD_LONG;
        end
      end
      default: cnt_n = {1'b0, cnt_q} + 9'd1;
    endcase
    // Drop the frame once the count reaches its length
    if (cnt_n > {1'b0, sfr_pkg::ADDR_POS} && cnt_n >= {1'b0, exp_d}) cnt_n = 9'd0;
  end

  assign cmd_push_o = accept && emit;
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 8'd0;
      exp_q       <= 8'd0;
      station_q   <= 8'd0;
      long_pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) station_q <= cfg_wdata_i;
      if (accept) begin
        cnt_q <= cnt_n[7:0];
        exp_q <= exp_d;
      end
      if (accept && emit && cmd == sfr_pkg::CMD_LONG) long_pend_q <= 1'b1;
      else if (run_done_i) long_pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cnt_q == sfr_pkg::ADDR_POS) addr_byte_q <= rx_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (accept && cnt_q < 8'(Depth)) mem[cnt_q[AW-1:0]] <= rx_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o           = rd_data_q;
  assign stat_o.long_pending = long_pend_q;
  assign stat_o.item_taken   = accept;

endmodule

/* src/sfr_cmd_queue.sv */
module sfr_cmd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sfr_pkg::cmd_e      cmd_i,
  input  logic               pop_i,
  output sfr_pkg::cmd_e      cmd_o,
  output sfr_pkg::q_status_t stat_o
);

  localparam int unsigned PW = $clog2(sfr_pkg::CMD_Q_DEPTH);
  localparam int unsigned CW = $clog2(sfr_pkg::CMD_Q_DEPTH + 1);

  sfr_pkg::cmd_e   slot_q [sfr_pkg::CMD_Q_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == CW'(sfr_pkg::CMD_Q_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CW'(1);
        2'b01:   count_q <= count_q - CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= cmd_i;
  end

endmodule

/* src/sfr_back.sv */
module sfr_back #(
  parameter int unsigned Depth = sfr_pkg::FRAME_STORE_DEPTH,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sfr_pkg::q_status_t        q_stat_i,
  input  sfr_pkg::cmd_e             cmd_i,
  output logic                      q_pop_o,
  output logic                      run_done_o,
  output logic                      rd_en_o,
  output logic [AW-1:0]             rd_addr_o,
  input  logic [7:0]                rd_data_i,
  input  logic                      pop,
  output logic                      empty,
  output logic                      event_kind_o,
  output logic [7:0]                payload_byte_o,
  output logic [sfr_pkg::IDX_W-1:0] payload_index_o,
  output logic                      last_item_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [sfr_pkg::IDX_W-1:0] idx_q, idx_d;
  logic out_valid_q, out_free, load;
  logic ld_kind, ld_last;
  logic [7:0] ld_byte;
  logic [sfr_pkg::IDX_W-1:0] ld_idx;

  assign out_free  = !out_valid_q || pop;
  assign rd_addr_o = AW'(7'(idx_q) + 7'(sfr_pkg::PAYLOAD_FIRST));

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    q_pop_o    = 1'b0;
    rd_en_o    = 1'b0;
    run_done_o = 1'b0;
    load       = 1'b0;
    ld_kind    = sfr_pkg::KIND_SHORT;
    ld_byte    = 8'd0;
    ld_idx     = '0;
    ld_last    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          if (cmd_i == sfr_pkg::CMD_LONG) begin
            q_pop_o = 1'b1;
            idx_d   = '0;
            state_d = ST_READ;
          end else if (out_free) begin
            q_pop_o = 1'b1;
            load    = 1'b1;
          end
        end
      end
      ST_READ: begin
        rd_en_o = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // Read data holds until the next read, so wait here for the output slot
        if (out_free) begin
          load    = 1'b1;
          ld_kind = sfr_pkg::KIND_LONG;
          ld_byte = rd_data_i;
          ld_idx  = idx_q;
          ld_last = (idx_q == sfr_pkg::PAYLOAD_LAST_IDX);
          if (ld_last) begin
            run_done_o = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            idx_d   = idx_q + sfr_pkg::IDX_W'(1);
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (load) out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      event_kind_o    <= ld_kind;
      payload_byte_o  <= ld_byte;
      payload_index_o <= ld_idx;
      last_item_o     <= ld_last;
    end
  end

  assign empty = !out_valid_q;

endmodule

/* src/serial_frame_receiver.sv */
// Path: a short-frame event reaches the result ports through the command queue and the output
// register; a long frame's payload items go through the queue, a frame store read in ST_READ and
// the output register in ST_LOAD, one frame store read per item, 33 items per run.
// Throughput: one byte per cycle, except that input is held full from a long frame's end byte
// until its last payload item is loaded, and while the command queue holds two events.
// Reset: rst_ni low clears the frame count, length, station address, command queue and output slot at once.
module serial_frame_receiver #(
  parameter int unsigned FRAME_STORE_DEPTH = sfr_pkg::FRAME_STORE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [7:0]                cfg_wdata_i,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                rx_byte_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      event_kind_o,
  output logic [7:0]                payload_byte_o,
  output logic [sfr_pkg::IDX_W-1:0] payload_index_o,
  output logic                      last_item_o
);

  localparam int unsigned AW = $clog2(FRAME_STORE_DEPTH);

  logic                   cmd_push, q_pop, run_done, rd_en;
  sfr_pkg::cmd_e          cmd_in, cmd_out;
  sfr_pkg::q_status_t     q_stat;
  sfr_pkg::front_status_t f_stat;
  logic [AW-1:0]          rd_addr;
  logic [7:0]             rd_data;

  sfr_front #(.Depth(FRAME_STORE_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .rx_byte_i   (rx_byte_i),
    .full        (full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .q_stat_i    (q_stat),
    .run_done_i  (run_done),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data),
    .stat_o      (f_stat)
  );

  sfr_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd_in),
    .pop_i  (q_pop),
    .cmd_o  (cmd_out),
    .stat_o (q_stat)
  );

  sfr_back #(.Depth(FRAME_STORE_DEPTH)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_stat_i        (q_stat),
    .cmd_i           (cmd_out),
    .q_pop_o         (q_pop),
    .run_done_o      (run_done),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .pop             (pop),
    .empty           (empty),
    .event_kind_o    (event_kind_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .last_item_o     (last_item_o)
  );

  a_pending_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_stat.long_pending |-> full)
    else $error("input open while a payload run is pending");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_stat.item_taken |-> !q_stat.full)
    else $error("item taken with command queue full");

  a_short_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_kind_o == sfr_pkg::KIND_SHORT) |-> (last_item_o && payload_byte_o == 8'd0))
    else $error("malformed short-frame event");

  a_run_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_done |=> (!empty && last_item_o && payload_index_o == sfr_pkg::PAYLOAD_LAST_IDX))
    else $error("payload run ended without its last item");

endmodule
